/* rtl/huffman_code_bit_packer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the code bit packer.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared constants and types of the code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    // Table size and code limits.
    localparam int SYMBOLS       = 256;
    localparam int MAX_CODE_BITS = 32;
    localparam int OUT_BITS      = 8;

    // Field widths of a request.
    localparam int OP_W    = 2;
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int IN_W    = SYM_W + CODE_W + LEN_W;
    localparam int TDATA_W = ((IN_W + 7) / 8) * 8;

    // Longest length that a load may store.
    localparam int LEN_CAP = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

    // Table addressing.
    localparam int IDX_W   = $clog2(SYMBOLS);
    localparam int ENTRY_W = CODE_W + LEN_W;
    localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOLS);

    // Packing window: pending bits plus one full code word.
    localparam int ACC_W  = OUT_BITS - 1;
    localparam int PEND_W = $clog2(OUT_BITS);
    localparam int BUF_W  = CODE_W + OUT_BITS;
    localparam int CNT_W  = $clog2(BUF_W);

    // Request kinds.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } opcode_t;

endpackage

/* rtl/hcbp_ram.sv */
// ----------------------------------------------------------------------------
// hcbp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/huffman_code_bit_packer.sv */
// An encode request goes through the lookup state and, if a byte fills, the emit state,
// which sends up to 4 bytes; a flush with pending bits emits one byte. One request is
// worked on at a time; bytes leave one a cycle unless m_tready stalls the output.
// The pace is set by the registered table read and the single output register.
// Reset clears the pending bits and the per-entry valid bits at once; no sweep.
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Looks up per-symbol code words in a table RAM and packs their bits, most
// significant first, into bytes. Flush pads a partial byte with zeros.
// ----------------------------------------------------------------------------
`include "huffman_code_bit_packer_assert.svh"

module huffman_code_bit_packer (
    input  logic                         clk,
    input  logic                         rst_n,
    // Request stream.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // From bit 0 up: symbol[8], code_word[32], code_length[6], zero pad[2].
    input  logic [hcbp_pkg::TDATA_W-1:0] s_tdata,
    // From bit 0 up: opcode[2].
    input  logic [hcbp_pkg::OP_W-1:0]    s_tuser,
    // Result stream.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // From bit 0 up: out_byte[8].
    output logic [7:0]                   m_tdata,
    output logic                         m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    // Request fields.
    hcbp_pkg::opcode_t                 in_op;
    logic [hcbp_pkg::SYM_W-1:0]        in_symbol;
    logic [hcbp_pkg::CODE_W-1:0]       in_code;
    logic [hcbp_pkg::LEN_W-1:0]        in_len;
    logic [hcbp_pkg::LEN_W-1:0]        in_len_sat;
    logic [hcbp_pkg::IDX_W-1:0]        in_idx;
    logic                              in_range;
    logic                              in_fire;

    // Table RAM ports.
    logic                              ram_we;
    logic                              ram_re;
    logic [hcbp_pkg::ENTRY_W-1:0]      ram_wdata;
    logic [hcbp_pkg::ENTRY_W-1:0]      ram_rdata;
    logic [hcbp_pkg::CODE_W-1:0]       rd_code;
    logic [hcbp_pkg::LEN_W-1:0]        rd_len;
    logic [hcbp_pkg::CODE_W-1:0]       rd_code_masked;
    logic [hcbp_pkg::CNT_W-1:0]        rd_total;
    logic [hcbp_pkg::CNT_W:0]          rd_shamt_wide;
    logic [hcbp_pkg::CNT_W-1:0]        rd_shamt;
    logic [hcbp_pkg::BUF_W-1:0]        rd_window;

    // State and registered outputs.
    state_t                            state_reg, state_next;
    logic [hcbp_pkg::SYMBOLS-1:0]      valid_reg, valid_next;
    logic                              hit_reg, hit_next;
    logic [hcbp_pkg::ACC_W-1:0]        acc_reg, acc_next;
    logic [hcbp_pkg::PEND_W-1:0]       pend_reg, pend_next;
    logic [hcbp_pkg::BUF_W-1:0]        buf_reg, buf_next;
    logic [hcbp_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [hcbp_pkg::CNT_W-1:0]        cnt_left;
    logic                              m_valid_reg, m_valid_next;
    logic [7:0]                        m_data_reg, m_data_next;
    logic                              m_last_reg, m_last_next;

    // Unpack the request and saturate the load length.
    assign in_op     = hcbp_pkg::opcode_t'(s_tuser);
    assign in_symbol = s_tdata[hcbp_pkg::SYM_W-1:0];
    assign in_code   = s_tdata[hcbp_pkg::SYM_W +: hcbp_pkg::CODE_W];
    assign in_len    = s_tdata[hcbp_pkg::SYM_W + hcbp_pkg::CODE_W +: hcbp_pkg::LEN_W];
    assign in_len_sat = (in_len > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP))
                        ? hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP) : in_len;
    assign in_idx    = in_symbol[hcbp_pkg::IDX_W-1:0];
    assign in_range  = ({1'b0, in_symbol} < hcbp_pkg::SYM_LIMIT);
    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    assign ram_wdata = {in_code, in_len_sat};

    // Code and length table, one entry per symbol.
    hcbp_ram #(
        .WIDTH (hcbp_pkg::ENTRY_W),
        .DEPTH (hcbp_pkg::SYMBOLS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    // Place the looked-up code just below the pending bits, left-aligned.
    assign rd_code        = ram_rdata[hcbp_pkg::ENTRY_W-1:hcbp_pkg::LEN_W];
    assign rd_len         = ram_rdata[hcbp_pkg::LEN_W-1:0];
    assign rd_code_masked = rd_code & ~({hcbp_pkg::CODE_W{1'b1}} << rd_len);
    assign rd_total       = hcbp_pkg::CNT_W'(pend_reg) + hcbp_pkg::CNT_W'(rd_len);
    assign rd_shamt_wide  = (hcbp_pkg::CNT_W + 1)'(hcbp_pkg::BUF_W) - {1'b0, rd_total};
    assign rd_shamt       = rd_shamt_wide[hcbp_pkg::CNT_W-1:0];
    assign rd_window      = {acc_reg, {(hcbp_pkg::BUF_W - hcbp_pkg::ACC_W){1'b0}}}
                          | ({{hcbp_pkg::OUT_BITS{1'b0}}, rd_code_masked} << rd_shamt);

    assign cnt_left = cnt_reg - hcbp_pkg::CNT_W'(hcbp_pkg::OUT_BITS);

    // Next-state logic for the request sequencer and the output register.
    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        hit_next     = hit_reg;
        acc_next     = acc_reg;
        pend_next    = pend_reg;
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_op)
                        hcbp_pkg::OP_LOAD:
                        begin
                            if (in_range)
                            begin
                                ram_we             = 1'b1;
                                valid_next[in_idx] = 1'b1;
                            end
                        end
                        hcbp_pkg::OP_ENCODE:
                        begin
                            ram_re     = 1'b1;
                            hit_next   = in_range && valid_reg[in_idx];
                            state_next = ST_LOOKUP;
                        end
                        hcbp_pkg::OP_FLUSH:
                        begin
                            // A partial byte goes out through the emit path.
                            if (pend_reg != '0)
                            begin
                                buf_next   = {acc_reg,
                                              {(hcbp_pkg::BUF_W - hcbp_pkg::ACC_W){1'b0}}};
                                cnt_next   = hcbp_pkg::CNT_W'(hcbp_pkg::OUT_BITS);
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                // An unknown or zero-length symbol leaves the pending bits alone.
                if (!hit_reg || rd_len == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (rd_total < hcbp_pkg::CNT_W'(hcbp_pkg::OUT_BITS))
                begin
                    acc_next   = rd_window[hcbp_pkg::BUF_W-1 -: hcbp_pkg::ACC_W];
                    pend_next  = rd_total[hcbp_pkg::PEND_W-1:0];
                    state_next = ST_IDLE;
                end
                else
                begin
                    buf_next   = rd_window;
                    cnt_next   = rd_total;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Send the top byte once the output register is free.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = buf_reg[hcbp_pkg::BUF_W-1 -: hcbp_pkg::OUT_BITS];
                    m_last_next  = (cnt_left < hcbp_pkg::CNT_W'(hcbp_pkg::OUT_BITS));
                    buf_next     = buf_reg << hcbp_pkg::OUT_BITS;
                    cnt_next     = cnt_left;
                    if (cnt_left < hcbp_pkg::CNT_W'(hcbp_pkg::OUT_BITS))
                    begin
                        acc_next   = buf_reg[hcbp_pkg::BUF_W-hcbp_pkg::OUT_BITS-1 -:
                                             hcbp_pkg::ACC_W];
                        pend_next  = cnt_left[hcbp_pkg::PEND_W-1:0];
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            hit_reg     <= 1'b0;
            acc_reg     <= '0;
            pend_reg    <= '0;
            buf_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            hit_reg     <= hit_next;
            acc_reg     <= acc_next;
            pend_reg    <= pend_next;
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            m_last_reg  <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // A lookup cycle only ever follows an accepted request.
    `HCBP_ASSERT_SAME(a_lookup_after_accept, clk, rst_n, state_reg == ST_LOOKUP,
        $past(s_tvalid && s_tready), "lookup without an accepted request")

    // The emit state only runs while a full byte remains.
    `HCBP_ASSERT_SAME(a_emit_has_byte, clk, rst_n, state_reg == ST_EMIT,
        cnt_reg >= hcbp_pkg::CNT_W'(hcbp_pkg::OUT_BITS), "emit with less than a byte")

    // A flush with pending bits must schedule exactly one byte.
    `HCBP_ASSERT_NEXT(a_flush_emits, clk, rst_n,
        s_tvalid && s_tready && in_op == hcbp_pkg::OP_FLUSH && pend_reg != '0,
        state_reg == ST_EMIT && cnt_reg == hcbp_pkg::CNT_W'(hcbp_pkg::OUT_BITS),
        "flush did not schedule its byte")

    // Output data only appears from the emit state.
    `HCBP_ASSERT_SAME(a_output_from_emit, clk, rst_n, $rose(m_valid_reg),
        $past(state_reg == ST_EMIT), "result raised outside the emit state")

endmodule
